[hdl/assert_macros.svh]
// Assertion helpers shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising clock edge, off while reset is low.
`define CHK_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("port check failed");

// Next-cycle implication, off while reset is low.
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("port check failed");

`endif

[hdl/smri_pkg.sv]
// ----------------------------------------------------------------------------
// smri_pkg
// Shared types and constants of the stepper ramp interpolator.
// ----------------------------------------------------------------------------
package smri_pkg;

	localparam int NUM_AXES = 4;
	localparam int STEP_W = 24;
	localparam int AXIS_W = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;
	localparam int LEN_W = 23;
	localparam int PER_W = 16;
	localparam int DIVD_W = 48;
	localparam int DIVS_W = 25;
	localparam int DCNT_W = 6;

	localparam logic [PER_W-1:0] START_PERIOD_RST = 16'd10000;
	localparam logic [PER_W-1:0] MIN_PERIOD_RST = 16'd1000;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_TICK = 1'b1;

	localparam logic CFG_START_PERIOD = 1'b0;
	localparam logic CFG_MIN_PERIOD = 1'b1;

	localparam logic [1:0] STEP_NONE = 2'd0;
	localparam logic [1:0] STEP_FWD = 2'd1;
	localparam logic [1:0] STEP_BWD = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_AX_MUL,
		ST_AX_DIV,
		ST_RAMP,
		ST_R_DIV,
		ST_WB
	} smri_state_t;

endpackage

[hdl/smri_div.sv]
// ----------------------------------------------------------------------------
// smri_div
// Restoring divider, one quotient bit per cycle, shared by all divisions.
// ----------------------------------------------------------------------------
module smri_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [smri_pkg::DIVD_W-1:0]   dividend,
	input  logic [smri_pkg::DIVS_W-1:0]   divisor,
	output logic                          done,
	output logic [smri_pkg::DIVD_W-1:0]   quotient
);
	import smri_pkg::*;

	logic                busy_q;
	logic                done_q;
	logic [DCNT_W-1:0]   cnt_q;
	logic [DIVS_W-1:0]   rem_q;
	logic [DIVD_W-1:0]   quo_q;
	logic [DIVS_W-1:0]   dvs_q;
	logic [DIVS_W:0]     trial;
	logic [DIVS_W:0]     diff;

	assign trial = {rem_q, quo_q[DIVD_W-1]};
	assign diff = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DCNT_W'(DIVD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (!diff[DIVS_W]) begin
				rem_q <= diff[DIVS_W-1:0];
				quo_q <= {quo_q[DIVD_W-2:0], 1'b1};
			end else begin
				rem_q <= trial[DIVS_W-1:0];
				quo_q <= {quo_q[DIVD_W-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quotient = quo_q;

endmodule

[hdl/stepper_move_ramp_interpolator.sv]
// ----------------------------------------------------------------------------
// stepper_move_ramp_interpolator
// Four-axis stepper move interpolator with a linear speed ramp.
// ----------------------------------------------------------------------------
// One beat in gives one beat out. A load, a tick with no active move and the
// tick that reports done go straight from decode to write-back. An active
// tick runs four axis-target divisions on one 48-step restoring divider,
// then a period ramp division, which is skipped on the final tick or when
// accelerating already at the minimum period. in_stall stays high while an
// item is worked on; the next item can be taken while a result still waits
// in the output register. Period registers written as 0 act as 1.
module stepper_move_ramp_interpolator (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic                          cfg_idx,
	input  logic [smri_pkg::PER_W-1:0]    cfg_wdata,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          opcode,
	input  logic signed [smri_pkg::STEP_W-1:0] delta_x,
	input  logic signed [smri_pkg::STEP_W-1:0] delta_y,
	input  logic signed [smri_pkg::STEP_W-1:0] delta_z,
	input  logic signed [smri_pkg::STEP_W-1:0] delta_e,
	input  logic [smri_pkg::LEN_W-1:0]    move_length,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [1:0]                    step_x,
	output logic [1:0]                    step_y,
	output logic [1:0]                    step_z,
	output logic [1:0]                    step_e,
	output logic [smri_pkg::PER_W-1:0]    timer_period,
	output logic                          busy_res,
	output logic                          move_done,
	output logic                          load_accepted
);
	import smri_pkg::*;

	smri_state_t state_q, state_d;

	logic [PER_W-1:0] sp_cfg_q, mp_cfg_q, sp_eff, mp_eff;

	// latched item
	logic                     op_q;
	logic signed [STEP_W-1:0] in_dlt_q [NUM_AXES];
	logic [LEN_W-1:0]         in_len_q;
	logic signed [STEP_W-1:0] in_dlt [NUM_AXES];

	// move state
	logic                     active_q;
	logic [LEN_W-1:0]         ti_q, len_q, accel_q;
	logic [PER_W-1:0]         rc_q, cp_q;
	logic signed [STEP_W-1:0] prog_q [NUM_AXES];
	logic signed [STEP_W-1:0] dlt_q [NUM_AXES];
	logic [AXIS_W-1:0]        axis_q;
	logic                     ramp_dec_q;

	// per-item result
	logic [1:0]               steps_q [NUM_AXES];
	logic                     done_q, acc_q;

	// output register
	logic                     out_valid_q;
	logic [1:0]               ostep_q [NUM_AXES];
	logic [PER_W-1:0]         otp_q;
	logic                     obusy_q, odone_q, oacc_q;

	// divider
	logic                     div_start, div_done;
	logic [DIVD_W-1:0]        div_dividend, div_q;
	logic [DIVS_W-1:0]        div_divisor;

	logic signed [STEP_W-1:0] cur_d;
	logic [STEP_W-1:0]        mag_d;
	logic [LEN_W-1:0]         left;
	logic                     accel_go, ramp_go, last_axis, wb_ok;
	logic signed [STEP_W:0]   tgt, prog_ext;
	logic [PER_W-1:0]         q16, rc_new;
	logic [PER_W:0]           grown;

	assign sp_eff = (sp_cfg_q == '0) ? PER_W'(1) : sp_cfg_q;
	assign mp_eff = (mp_cfg_q == '0) ? PER_W'(1) : mp_cfg_q;

	assign in_dlt[0] = delta_x;
	assign in_dlt[1] = delta_y;
	assign in_dlt[2] = delta_z;
	assign in_dlt[3] = delta_e;

	assign cur_d = dlt_q[axis_q];
	assign mag_d = cur_d[STEP_W-1] ? STEP_W'(-cur_d) : STEP_W'(cur_d);
	assign left = len_q - ti_q;
	assign accel_go = left > accel_q;
	assign ramp_go = accel_go ? (cp_q != mp_eff) : (left != '0);
	assign last_axis = axis_q == AXIS_W'(NUM_AXES - 1);
	assign wb_ok = !out_valid_q || !out_stall;

	// C-style truncation: divide magnitudes, then restore the sign
	assign tgt = cur_d[STEP_W-1] ? -$signed({1'b0, div_q[STEP_W-1:0]})
		: $signed({1'b0, div_q[STEP_W-1:0]});
	assign prog_ext = {prog_q[axis_q][STEP_W-1], prog_q[axis_q]};
	assign q16 = div_q[PER_W-1:0];
	assign rc_new = rc_q - q16;
	assign grown = {1'b0, cp_q} + {1'b0, q16};

	smri_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_q)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_DECODE;
			end
			ST_DECODE: begin
				if (op_q == OP_TICK && active_q && len_q != '0) state_d = ST_AX_MUL;
				else state_d = ST_WB;
			end
			ST_AX_MUL: state_d = ST_AX_DIV;
			ST_AX_DIV: begin
				if (div_done) begin
					if (!last_axis) state_d = ST_AX_MUL;
					else if (ti_q < len_q) state_d = ST_RAMP;
					else state_d = ST_WB;
				end
			end
			ST_RAMP: state_d = ramp_go ? ST_R_DIV : ST_WB;
			ST_R_DIV: begin
				if (div_done) state_d = ST_WB;
			end
			ST_WB: begin
				if (wb_ok) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		in_stall = 1'b1;
		div_start = 1'b0;
		div_dividend = DIVD_W'(ti_q) * DIVD_W'(mag_d);
		div_divisor = DIVS_W'(len_q);
		case (state_q)
			ST_IDLE: in_stall = 1'b0;
			ST_AX_MUL: div_start = 1'b1;
			ST_RAMP: begin
				div_start = ramp_go;
				if (accel_go) begin
					div_dividend = DIVD_W'({rc_q, 1'b0});
					div_divisor = {ti_q, 2'b00} + DIVS_W'(1);
				end else begin
					div_dividend = DIVD_W'({cp_q, 1'b0});
					div_divisor = {left, 2'b00} - DIVS_W'(1);
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_cfg_q <= START_PERIOD_RST;
			mp_cfg_q <= MIN_PERIOD_RST;
		end else if (cfg_we) begin
			if (cfg_idx == CFG_START_PERIOD) sp_cfg_q <= cfg_wdata;
			if (cfg_idx == CFG_MIN_PERIOD) mp_cfg_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			op_q <= opcode;
			in_len_q <= move_length;
			for (int a = 0; a < NUM_AXES; a++) begin
				in_dlt_q[a] <= (a < 4) ? in_dlt[a] : '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			ti_q <= '0;
			len_q <= '0;
			accel_q <= '0;
			rc_q <= START_PERIOD_RST;
			cp_q <= START_PERIOD_RST;
			axis_q <= '0;
			ramp_dec_q <= 1'b0;
			done_q <= 1'b0;
			acc_q <= 1'b0;
			for (int a = 0; a < NUM_AXES; a++) begin
				prog_q[a] <= '0;
				dlt_q[a] <= '0;
				steps_q[a] <= STEP_NONE;
			end
		end else begin
			case (state_q)
				ST_DECODE: begin
					done_q <= 1'b0;
					acc_q <= 1'b0;
					axis_q <= '0;
					for (int a = 0; a < NUM_AXES; a++) steps_q[a] <= STEP_NONE;
					if (op_q == OP_LOAD) begin
						if (!active_q) begin
							for (int a = 0; a < NUM_AXES; a++) begin
								dlt_q[a] <= in_dlt_q[a];
								prog_q[a] <= '0;
							end
							len_q <= in_len_q;
							ti_q <= '0;
							accel_q <= '0;
							rc_q <= sp_eff;
							cp_q <= sp_eff;
							active_q <= 1'b1;
							acc_q <= 1'b1;
						end
					end else if (active_q && len_q == '0) begin
						active_q <= 1'b0;
						ti_q <= '0;
						rc_q <= sp_eff;
						cp_q <= sp_eff;
						done_q <= 1'b1;
					end
				end
				ST_AX_DIV: begin
					if (div_done) begin
						if (!cur_d[STEP_W-1] && cur_d != '0 && prog_ext < tgt) begin
							prog_q[axis_q] <= prog_q[axis_q] + 1'b1;
							steps_q[axis_q] <= STEP_FWD;
						end else if (cur_d[STEP_W-1] && prog_ext > tgt) begin
							prog_q[axis_q] <= prog_q[axis_q] - 1'b1;
							steps_q[axis_q] <= STEP_BWD;
						end
						if (last_axis) begin
							if (ti_q < len_q) begin
								ti_q <= ti_q + 1'b1;
							end else begin
								len_q <= '0;
								accel_q <= '0;
							end
						end else begin
							axis_q <= axis_q + 1'b1;
						end
					end
				end
				ST_RAMP: ramp_dec_q <= !accel_go;
				ST_R_DIV: begin
					if (div_done) begin
						if (!ramp_dec_q) begin
							accel_q <= accel_q + 1'b1;
							rc_q <= rc_new;
							cp_q <= (rc_new >= mp_eff) ? rc_new : mp_eff;
						end else begin
							// ceiling at the start period
							cp_q <= (grown > {1'b0, sp_eff}) ? sp_eff : grown[PER_W-1:0];
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_WB && wb_ok) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_WB && wb_ok) begin
			for (int a = 0; a < NUM_AXES; a++) ostep_q[a] <= steps_q[a];
			otp_q <= cp_q;
			obusy_q <= active_q;
			odone_q <= done_q;
			oacc_q <= acc_q;
		end
	end

	assign out_valid = out_valid_q;
	assign step_x = ostep_q[0];
	assign step_y = ostep_q[1];
	assign step_z = ostep_q[2];
	assign step_e = ostep_q[3];
	assign timer_period = otp_q;
	assign busy_res = obusy_q;
	assign move_done = odone_q;
	assign load_accepted = oacc_q;

endmodule

[hdl/smri_chk.sv]
// ----------------------------------------------------------------------------
// smri_chk
// Port-level checks of the stepper ramp interpolator, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module smri_chk (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          in_stall,
	input  logic                          out_valid,
	input  logic                          out_stall,
	input  logic [1:0]                    step_x,
	input  logic [1:0]                    step_y,
	input  logic [1:0]                    step_z,
	input  logic [1:0]                    step_e,
	input  logic [smri_pkg::PER_W-1:0]    timer_period,
	input  logic                          busy_res,
	input  logic                          move_done,
	input  logic                          load_accepted
);
	import smri_pkg::*;

	logic out_held;
	logic no_step;

	assign out_held = out_valid && out_stall;
	assign no_step = step_x == STEP_NONE && step_y == STEP_NONE
		&& step_z == STEP_NONE && step_e == STEP_NONE;

	// a stalled beat holds
	`CHK_NEXT(a_out_hold, clk, arst_n, out_held, out_valid)
	`CHK_NEXT(a_out_stable, clk, arst_n, out_held, $stable(timer_period) && $stable(busy_res))
	// finishing a move leaves the block idle
	`CHK_IMPL(a_done_idle, clk, arst_n, out_valid && move_done, !busy_res && !load_accepted)
	// a taken load starts a move and steps nothing
	`CHK_IMPL(a_load_quiet, clk, arst_n, out_valid && load_accepted, busy_res && no_step)
	`CHK_IMPL(a_period_nz, clk, arst_n, out_valid, timer_period != '0)

endmodule

bind stepper_move_ramp_interpolator smri_chk u_smri_chk (.*);

[bench/stepper_move_ramp_interpolator_tb.sv]
// ----------------------------------------------------------------------------
// stepper_move_ramp_interpolator_tb
// Self-checking bench for the stepper ramp interpolator. A scoreboard class
// predicts the steps, timer period and status of every beat and compares
// them with the block's results. The stimulus is directed moves, then random
// moves under several period settings, with random idling on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stepper_move_ramp_interpolator_tb;
	import smri_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int TARGET_ITEMS = 1000;
	localparam int DRAIN_CYCLES = 300;

	typedef struct packed {
		logic [1:0]       sx;
		logic [1:0]       sy;
		logic [1:0]       sz;
		logic [1:0]       se;
		logic [PER_W-1:0] per;
		logic             busy;
		logic             done;
		logic             acc;
	} ramp_result_t;

	class ramp_scoreboard;
		logic [PER_W-1:0] start_p;
		logic [PER_W-1:0] min_p;
		bit               moving;
		int unsigned      tick_idx;
		int unsigned      len_left;
		int unsigned      accel_cnt;
		int unsigned      ramp_cnt;
		int unsigned      cur_per;
		longint           progress [NUM_AXES];
		longint           delta [NUM_AXES];
		ramp_result_t     pending [$];
		int               mismatches;

		function new();
			start_p = START_PERIOD_RST;
			min_p = MIN_PERIOD_RST;
			moving = 0;
			tick_idx = 0;
			len_left = 0;
			accel_cnt = 0;
			ramp_cnt = START_PERIOD_RST;
			cur_per = START_PERIOD_RST;
			mismatches = 0;
			for (int a = 0; a < NUM_AXES; a++) begin
				progress[a] = 0;
				delta[a] = 0;
			end
		endfunction

		function void set_reg(logic idx, logic [PER_W-1:0] val);
			if (idx == CFG_START_PERIOD) start_p = val;
			else min_p = val;
		endfunction

		function int unsigned floor_one(logic [PER_W-1:0] v);
			return (v == 0) ? 1 : int'(v);
		endfunction

		function void advance_ramp();
			int unsigned sp, mp, left, grown;
			sp = floor_one(start_p);
			mp = floor_one(min_p);
			left = len_left - tick_idx;
			if (left > accel_cnt) begin
				if (cur_per != mp) begin
					accel_cnt++;
					ramp_cnt = ramp_cnt - (2 * ramp_cnt) / (4 * tick_idx + 1);
					cur_per = (ramp_cnt >= mp) ? ramp_cnt : mp;
				end
			end else if (left != 0) begin
				grown = cur_per + (2 * cur_per) / (4 * left - 1);
				cur_per = (grown > sp) ? sp : grown;
			end
		endfunction

		function void note_item(logic op, logic signed [STEP_W-1:0] dx,
				logic signed [STEP_W-1:0] dy, logic signed [STEP_W-1:0] dz,
				logic signed [STEP_W-1:0] de, logic [LEN_W-1:0] len);
			ramp_result_t r;
			longint tgt;
			logic [1:0] st [NUM_AXES];
			for (int a = 0; a < NUM_AXES; a++) st[a] = STEP_NONE;
			r = '0;
			if (op == OP_LOAD) begin
				if (!moving) begin
					delta[0] = longint'(dx);
					delta[1] = longint'(dy);
					delta[2] = longint'(dz);
					delta[3] = longint'(de);
					for (int a = 0; a < NUM_AXES; a++) progress[a] = 0;
					len_left = len;
					tick_idx = 0;
					accel_cnt = 0;
					ramp_cnt = floor_one(start_p);
					cur_per = ramp_cnt;
					moving = 1;
					r.acc = 1;
				end
			end else if (moving) begin
				if (len_left != 0) begin
					for (int a = 0; a < NUM_AXES; a++) begin
						tgt = (longint'(tick_idx) * delta[a]) / longint'(len_left);
						if (delta[a] > 0 && progress[a] < tgt) begin
							progress[a]++;
							st[a] = STEP_FWD;
						end else if (delta[a] < 0 && progress[a] > tgt) begin
							progress[a]--;
							st[a] = STEP_BWD;
						end
					end
					if (tick_idx < len_left) begin
						tick_idx++;
						advance_ramp();
					end else begin
						// last tick: steps only, ramp skipped
						len_left = 0;
						accel_cnt = 0;
					end
				end else begin
					moving = 0;
					tick_idx = 0;
					ramp_cnt = floor_one(start_p);
					cur_per = ramp_cnt;
					r.done = 1;
				end
			end
			r.sx = st[0];
			r.sy = st[1];
			r.sz = st[2];
			r.se = st[3];
			r.per = cur_per[PER_W-1:0];
			r.busy = moving;
			pending.push_back(r);
		endfunction

		function void check_result(ramp_result_t got);
			ramp_result_t exp;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: result beat with nothing expected: %p", $time, got);
				return;
			end
			exp = pending.pop_front();
			if (got.sx !== exp.sx || got.sy !== exp.sy || got.sz !== exp.sz ||
					got.se !== exp.se || got.per !== exp.per || got.busy !== exp.busy ||
					got.done !== exp.done || got.acc !== exp.acc) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: mismatch exp %p got %p", $time, exp, got);
			end
		endfunction
	endclass

	logic                     clk = 0;
	logic                     arst_n = 0;
	logic                     cfg_we = 0;
	logic                     cfg_idx = CFG_START_PERIOD;
	logic [PER_W-1:0]         cfg_wdata = '0;
	logic                     in_valid = 0;
	logic                     in_stall;
	logic                     opcode = OP_LOAD;
	logic signed [STEP_W-1:0] delta_x = '0;
	logic signed [STEP_W-1:0] delta_y = '0;
	logic signed [STEP_W-1:0] delta_z = '0;
	logic signed [STEP_W-1:0] delta_e = '0;
	logic [LEN_W-1:0]         move_length = '0;
	logic                     out_valid;
	logic                     out_stall = 0;
	logic [1:0]               step_x, step_y, step_z, step_e;
	logic [PER_W-1:0]         timer_period;
	logic                     busy_res, move_done, load_accepted;

	ramp_scoreboard sb = new();
	bit quiet = 0;
	bit hold_req = 0;
	int items_sent = 0;
	int idle_cycles = 0;

	stepper_move_ramp_interpolator u_dut (.*);

	always #5 clk = ~clk;

	// result side: random stall, one long hold-off on request
	int hold_left = 0;
	bit hold_done = 0;
	always @(posedge clk) begin
		if (out_valid && !out_stall)
			sb.check_result({step_x, step_y, step_z, step_e, timer_period,
				busy_res, move_done, load_accepted});
		if (hold_req && !hold_done) begin
			hold_done <= 1;
			hold_left <= 600;
			out_stall <= 1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1;
		end else begin
			out_stall <= !quiet && ($urandom_range(0, 99) < 33);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WATCHDOG_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	task automatic send_beat(logic op, logic signed [STEP_W-1:0] dx,
			logic signed [STEP_W-1:0] dy, logic signed [STEP_W-1:0] dz,
			logic signed [STEP_W-1:0] de, logic [LEN_W-1:0] len);
		int gap;
		gap = (!quiet && $urandom_range(0, 99) < 33) ? $urandom_range(1, 4) : 0;
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1;
		opcode <= op;
		delta_x <= dx;
		delta_y <= dy;
		delta_z <= dz;
		delta_e <= de;
		move_length <= len;
		do @(posedge clk); while (in_stall);
		sb.note_item(op, dx, dy, dz, de, len);
	endtask

	task automatic tick();
		send_beat(OP_TICK, STEP_W'($urandom), STEP_W'($urandom), STEP_W'($urandom),
			STEP_W'($urandom), LEN_W'($urandom));
		items_sent++;
	endtask

	function automatic logic signed [STEP_W-1:0] rand_delta(int len);
		if ($urandom_range(0, 1)) return STEP_W'($urandom);
		return STEP_W'($urandom_range(0, 4 * len + 4) - (2 * len + 2));
	endfunction

	task automatic wait_drained();
		while (sb.pending.size() != 0) @(posedge clk);
	endtask

	task automatic run_move(int len);
		send_beat(OP_LOAD, rand_delta(len), rand_delta(len), rand_delta(len),
			rand_delta(len), LEN_W'(len));
		items_sent++;
		for (int t = 0; t < len + 2; t++) begin
			// noise: a load that arrives mid-move is dropped
			if ($urandom_range(0, 99) < 5)
				send_beat(OP_LOAD, STEP_W'($urandom), STEP_W'($urandom),
					STEP_W'($urandom), STEP_W'($urandom), LEN_W'($urandom));
			tick();
		end
		if ($urandom_range(0, 99) < 10) tick();
	endtask

	task automatic set_periods(logic [PER_W-1:0] sp, logic [PER_W-1:0] mp);
		in_valid <= 0;
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_we <= 1;
		cfg_idx <= CFG_START_PERIOD;
		cfg_wdata <= sp;
		@(posedge clk);
		sb.set_reg(CFG_START_PERIOD, sp);
		cfg_idx <= CFG_MIN_PERIOD;
		cfg_wdata <= mp;
		@(posedge clk);
		sb.set_reg(CFG_MIN_PERIOD, mp);
		cfg_we <= 0;
	endtask

	logic [PER_W-1:0] sp_list [6] = '{16'd10000, 16'd65535, 16'd0, 16'd1, 16'd500, 16'd3000};
	logic [PER_W-1:0] mp_list [6] = '{16'd1000, 16'd1, 16'd0, 16'd65535, 16'd2000, 16'd40};

	initial begin
		int len;
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: idle tick, zero-length move, load while busy, extreme deltas
		tick();
		send_beat(OP_LOAD, 24'sh7FFFFF, -24'sh800000, 24'sd0, -24'sd1, 23'd0);
		send_beat(OP_LOAD, 24'sd1, 24'sd1, 24'sd1, 24'sd1, 23'd5);
		tick();
		tick();
		send_beat(OP_LOAD, 24'sh7FFFFF, -24'sh800000, 24'sd0, 24'sd5, 23'd3);
		repeat (5) tick();
		send_beat(OP_LOAD, -24'sd1, 24'sd1, 24'sd2, -24'sd3, 23'd1);
		repeat (4) tick();

		for (int ph = 0; ph < 6; ph++) begin
			set_periods(sp_list[ph], mp_list[ph]);
			quiet = (ph == 2);
			while (items_sent < (ph + 1) * TARGET_ITEMS / 6) begin
				len = ($urandom_range(0, 99) < 80) ? $urandom_range(0, 16)
					: $urandom_range(17, 120);
				if (ph == 1 && !hold_req && items_sent > 200) begin
					hold_req = 1;
					len = 40;
				end
				run_move(len);
			end
		end

		// longest move: a few ticks only, it cannot finish in this run
		quiet = 0;
		set_periods(PER_W'($urandom), PER_W'($urandom));
		send_beat(OP_LOAD, STEP_W'($urandom), STEP_W'($urandom), STEP_W'($urandom),
			STEP_W'($urandom), 23'h7FFFFF);
		repeat (12) tick();

		in_valid <= 0;
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
